@@ hw/rtl/pcf_pkg.sv @@
package pcf_pkg;

    localparam int COEF_FRAC_BITS = 10;
    localparam int COEF_W         = COEF_FRAC_BITS;
    localparam int GAIN_FRAC_BITS = 10;
    localparam int GAIN_W         = 14;
    localparam int CH_W           = 8;
    localparam int PROD_W         = CH_W + COEF_W;
    localparam int MSUM_W         = PROD_W + 2;
    localparam int BPROD_W        = CH_W + GAIN_W;
    localparam int SUM_W          = CH_W + 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = GAIN_W;
    localparam int QCOEF_DEN      = 1000;

    // floor(x/3) for x <= 765: (x * 683) >> 11
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_W     = SUM_W + 10;

    localparam logic [CH_W-1:0] THRESH_LEVEL = 8'd128;
    localparam logic [CH_W-1:0] CH_MAX       = 8'd255;

    typedef enum logic [3:0] {
        MODE_INVERT     = 4'd0,
        MODE_THRESHOLD  = 4'd1,
        MODE_SEPIA      = 4'd2,
        MODE_GREY       = 4'd3,
        MODE_BRIGHTNESS = 4'd4,
        MODE_MEAN_GREY  = 4'd5,
        MODE_NO_RED     = 4'd6,
        MODE_NO_BLUE    = 4'd7,
        MODE_NO_GREEN   = 4'd8
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_MODE     = 1'b0,
        REG_BRIGHTNESS_GAIN = 1'b1
    } cfg_reg_t;

    localparam mode_t          MODE_RESET = MODE_GREY;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 14'd1024;

    // round-half-up of (milli / 1000) in COEF_FRAC_BITS fraction bits
    function automatic logic [COEF_W-1:0] qcoef(input int milli);
        int scaled;
        scaled = ((milli << COEF_FRAC_BITS) + QCOEF_DEN / 2) / QCOEF_DEN;
        return scaled[COEF_W-1:0];
    endfunction

    typedef logic [0:2][0:2][COEF_W-1:0] coef_mat_t;

    localparam coef_mat_t SEPIA_COEF = '{
        '{qcoef(393), qcoef(769), qcoef(189)},
        '{qcoef(349), qcoef(686), qcoef(168)},
        '{qcoef(272), qcoef(534), qcoef(131)}
    };

    localparam coef_mat_t GREY_COEF = '{
        '{qcoef(299), qcoef(587), qcoef(114)},
        '{qcoef(299), qcoef(587), qcoef(114)},
        '{qcoef(299), qcoef(587), qcoef(114)}
    };

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } pixel_t;

    // after the multiply stage
    typedef struct packed {
        mode_t                          mode;
        pixel_t                         pix;
        logic [0:2][0:2][PROD_W-1:0]    mprod;
        logic [0:2][BPROD_W-1:0]        bprod;
        logic [SUM_W-1:0]               sum;
    } prod_word_t;

    // after the accumulate/clamp stage
    typedef struct packed {
        mode_t                    mode;
        pixel_t                   pix;
        logic [0:2][CH_W-1:0]     mat;
        logic [0:2][CH_W-1:0]     bri;
        logic [CH_W-1:0]          mean;
    } accum_word_t;

endpackage

@@ hw/rtl/pcf_prod_stage.sv @@
module pcf_prod_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  pcf_pkg::pixel_t     pix,
    input  pcf_pkg::mode_t      mode,
    input  logic [pcf_pkg::GAIN_W-1:0] gain,
    output logic                valid_reg,
    output pcf_pkg::prod_word_t word_reg
);
    import pcf_pkg::*;

    coef_mat_t              coef;
    prod_word_t             word_next;
    logic [0:2][CH_W-1:0]   ch;

    assign ch = '{pix.red, pix.green, pix.blue};

    always_comb
    begin
        coef = (mode == MODE_SEPIA) ? SEPIA_COEF : GREY_COEF;
        word_next.mode = mode;
        word_next.pix  = pix;
        for (int row = 0; row < 3; row++)
        begin
            for (int col = 0; col < 3; col++)
            begin
                word_next.mprod[row][col] = PROD_W'(ch[col]) * PROD_W'(coef[row][col]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            word_next.bprod[k] = BPROD_W'(ch[k]) * BPROD_W'(gain);
        end
        word_next.sum = SUM_W'(pix.red) + SUM_W'(pix.green) + SUM_W'(pix.blue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

@@ hw/rtl/pcf_accum_stage.sv @@
module pcf_accum_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  pcf_pkg::prod_word_t  prod,
    output logic                 valid_reg,
    output pcf_pkg::accum_word_t word_reg
);
    import pcf_pkg::*;

    accum_word_t                     word_next;
    logic [0:2][MSUM_W-1:0]          msum;
    logic [0:2][MSUM_W-COEF_FRAC_BITS-1:0] mshift;
    logic [0:2][BPROD_W-GAIN_FRAC_BITS-1:0] bshift;
    logic [DIV3_W-1:0]               div3;

    always_comb
    begin
        word_next.mode = prod.mode;
        word_next.pix  = prod.pix;
        for (int k = 0; k < 3; k++)
        begin
            msum[k] = MSUM_W'(prod.mprod[k][0]) + MSUM_W'(prod.mprod[k][1])
                    + MSUM_W'(prod.mprod[k][2]);
            mshift[k] = msum[k][MSUM_W-1:COEF_FRAC_BITS];
            word_next.mat[k] = (mshift[k] > CH_W'(CH_MAX)) ? CH_MAX : mshift[k][CH_W-1:0];
            bshift[k] = prod.bprod[k][BPROD_W-1:GAIN_FRAC_BITS];
            word_next.bri[k] = (bshift[k] > CH_W'(CH_MAX)) ? CH_MAX : bshift[k][CH_W-1:0];
        end
        div3 = DIV3_W'(prod.sum) * DIV3_W'(DIV3_MUL);
        word_next.mean = div3[DIV3_SHIFT +: CH_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    // mean is the exact floor of sum/3
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ((SUM_W'(word_next.mean) * SUM_W'(3) <= prod.sum)
                  && (prod.sum < SUM_W'(word_next.mean) * SUM_W'(3) + SUM_W'(3))))
        else $error("mean does not match sum/3");

endmodule

@@ hw/rtl/pixel_colour_filter_top.sv @@
// Per-pixel RGBA colour filter. One pixel word is accepted per clock while
// in_ready is high and moves through the multiply, accumulate/clamp and
// select/output registers; throughput is one pixel per clock as long as the
// sink keeps out_ready high, and each stage holds its word under a stall so
// in_ready only drops when all three stages are full and the output is
// blocked. filter_mode selects invert, threshold, sepia, greyscale (reset),
// brightness, mean grey or removal of one colour; codes 9..15 pass the pixel
// through. brightness_gain is an unsigned gain with 10 fraction bits (1024 is
// unity). Write the configuration registers only while no pixel is in flight.
module pixel_colour_filter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // pixel input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_red,
    input  logic [7:0]                    in_green,
    input  logic [7:0]                    in_blue,
    input  logic [7:0]                    in_alpha,
    // pixel output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_red,
    output logic [7:0]                    out_green,
    output logic [7:0]                    out_blue,
    output logic [7:0]                    out_alpha,
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pcf_pkg::*;

    // configuration registers
    mode_t              mode_reg;
    logic [GAIN_W-1:0]  gain_reg;

    // pipeline stage handshakes
    logic               s1_valid;
    logic               s2_valid;
    logic               adv1;
    logic               adv2;
    logic               adv3;
    prod_word_t         s1_word;
    accum_word_t        s2_word;
    pixel_t             in_pix;
    pixel_t             res_next;
    logic               out_valid_reg;
    pixel_t             res_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FILTER_MODE:     mode_reg <= mode_t'(cfg_data[3:0]);
                REG_BRIGHTNESS_GAIN: gain_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // A stage moves when its slot is empty or the next one moves.
    assign adv3     = !out_valid_reg || out_ready;
    assign adv2     = !s2_valid || adv3;
    assign adv1     = !s1_valid || adv2;
    assign in_ready = adv1;

    assign in_pix = '{red: in_red, green: in_green, blue: in_blue, alpha: in_alpha};

    // stage 1: all products and the channel sum
    pcf_prod_stage u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (adv1),
        .in_valid  (in_valid),
        .pix       (in_pix),
        .mode      (mode_reg),
        .gain      (gain_reg),
        .valid_reg (s1_valid),
        .word_reg  (s1_word)
    );

    // stage 2: row sums, shifts, clamps and mean
    pcf_accum_stage u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (adv2),
        .in_valid  (s1_valid),
        .prod      (s1_word),
        .valid_reg (s2_valid),
        .word_reg  (s2_word)
    );

    // stage 3: pick the result for the mode carried with the word
    always_comb
    begin
        res_next = s2_word.pix;
        case (s2_word.mode)
            MODE_INVERT:
            begin
                res_next.red   = CH_MAX - s2_word.pix.red;
                res_next.green = CH_MAX - s2_word.pix.green;
                res_next.blue  = CH_MAX - s2_word.pix.blue;
                res_next.alpha = CH_MAX - s2_word.pix.alpha;
            end
            MODE_THRESHOLD:
            begin
                res_next.red   = (s2_word.mean > THRESH_LEVEL) ? CH_MAX : '0;
                res_next.green = res_next.red;
                res_next.blue  = res_next.red;
            end
            MODE_SEPIA, MODE_GREY:
            begin
                res_next.red   = s2_word.mat[0];
                res_next.green = s2_word.mat[1];
                res_next.blue  = s2_word.mat[2];
            end
            MODE_BRIGHTNESS:
            begin
                res_next.red   = s2_word.bri[0];
                res_next.green = s2_word.bri[1];
                res_next.blue  = s2_word.bri[2];
            end
            MODE_MEAN_GREY:
            begin
                res_next.red   = s2_word.mean;
                res_next.green = s2_word.mean;
                res_next.blue  = s2_word.mean;
            end
            MODE_NO_RED:   res_next.red   = '0;
            MODE_NO_BLUE:  res_next.blue  = '0;
            MODE_NO_GREEN: res_next.green = '0;
            default:       ;   // unused codes pass through
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv3)
        begin
            out_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = res_reg.red;
    assign out_green = res_reg.green;
    assign out_blue  = res_reg.blue;
    assign out_alpha = res_reg.alpha;

    // input blocked only when every stage is full and the sink stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s2_valid && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted into a full, stalled pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid && s2_valid && out_valid_reg && !out_ready) |-> in_ready)
        else $error("input stalled while a bubble exists");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid)
        else $error("accepted word lost at stage 1");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(out_ready))
        else $error("output word dropped without handshake");

endmodule
